/* hdl/tlu_pkg.sv */
// Package for the table interpolation lookup block.
// Holds parameter defaults, command codes and register indexes.
// Depends on nothing.
package tlu_pkg;
   localparam int DEPTH_DEFAULT       = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int ONE_Q16             = 65536;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_ENTRY_COUNT   = 3'd0,
      CSR_SNAP_MODE     = 3'd1,
      CSR_CLAMP_MODE    = 3'd2,
      CSR_DISCONT_MODE  = 3'd3,
      CSR_LINEAR_SHORT  = 3'd4
   } csr_index_type;
endpackage

/* hdl/table_interp_lookup.sv */
// Top level of the table interpolation lookup block: one module, table memory inside.
// Depends on tlu_pkg.
//
// One word per cycle is accepted (busy stays low). Write words store a Q16.16 entry;
// lookup words produce one result on rsp_lookup_result, strobed by rsp_valid for one
// cycle; the receiver cannot stall. The pipeline is a scale multiplier, a two-read-port
// table memory, a blend multiplier and a round and saturate stage. Writes reach the
// memory at the same stage as lookup reads, so word order is kept without interlock.
// No reset sweep: the user must read entries only once written; it is not enforced.
module table_interp_lookup #(
   parameter int DEPTH       = tlu_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = tlu_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [7:0]         req_entry_address,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_lookup_index,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_lookup_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam logic signed [49:0] VW_HI = (50'sd1 <<< (VALUE_WIDTH - 1)) - 50'sd1;
   localparam logic signed [49:0] I32_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_HI = (VW_HI < I32_HI) ? VW_HI : I32_HI;
   localparam logic signed [49:0] SAT_LO = -SAT_HI - 50'sd1;

   logic [8:0] entry_count_ff;
   logic       snap_ff, clamp_ff, discont_ff, short_ff;

   logic signed [31:0] mem [DEPTH];

   logic               s1_vld_ff, s1_lkp_ff;
   logic [7:0]         s1_addr_ff;
   logic signed [31:0] s1_wdat_ff, s1_idx_ff;

   logic               s2_vld_ff, s2_lkp_ff, s2_clamp_ff, s2_spc_ff;
   logic [7:0]         s2_addr_ff;
   logic signed [31:0] s2_wdat_ff;
   logic signed [42:0] s2_prod_ff;
   logic [8:0]         s2_n_ff, s2_dm1_ff;
   logic signed [32:0] s2_spv_ff;

   logic               s3_vld_ff, s3_spc_ff;
   logic signed [31:0] s3_rd0_ff, s3_rd1_ff;
   logic [15:0]        s3_frac_ff;
   logic signed [32:0] s3_spv_ff;

   logic               s4_vld_ff, s4_spc_ff;
   logic signed [49:0] s4_mul_ff;
   logic signed [31:0] s4_v0_ff;
   logic signed [32:0] s4_spv_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_result_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 9'd1;
         snap_ff        <= 1'b0;
         clamp_ff       <= 1'b0;
         discont_ff     <= 1'b0;
         short_ff       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tlu_pkg::CSR_ENTRY_COUNT:  entry_count_ff <= csr_data[8:0];
            tlu_pkg::CSR_SNAP_MODE:    snap_ff        <= csr_data[0];
            tlu_pkg::CSR_CLAMP_MODE:   clamp_ff       <= csr_data[0];
            tlu_pkg::CSR_DISCONT_MODE: discont_ff     <= csr_data[0];
            tlu_pkg::CSR_LINEAR_SHORT: short_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   // stage 1: scale
   logic [8:0]         n_in, d_in, dm1_in, mb_in;
   logic signed [32:0] ma_in;
   logic signed [42:0] prod_in;
   logic               spc_in;
   logic signed [32:0] spv_in;

   always_comb begin
      n_in   = (32'(entry_count_ff) > DEPTH) ? 9'(DEPTH) : entry_count_ff;
      d_in   = n_in - {8'd0, discont_ff};
      dm1_in = d_in - 9'd1;
      mb_in  = clamp_ff ? dm1_in : d_in;
      ma_in  = clamp_ff ? {s1_idx_ff[31], s1_idx_ff} : {17'd0, s1_idx_ff[15:0]};
      prod_in = 43'(ma_in * $signed({1'b0, mb_in}));
      spc_in = (n_in < 9'd2) || short_ff;
      if (n_in < 9'd2) begin
         spv_in = 33'(tlu_pkg::ONE_Q16);
      end else if (s1_idx_ff < 0) begin
         spv_in = 33'sd0;
      end else if (s1_idx_ff > 32'(tlu_pkg::ONE_Q16)) begin
         spv_in = 33'(tlu_pkg::ONE_Q16);
      end else begin
         spv_in = {1'b0, s1_idx_ff};
      end
   end

   // stage 2: entry select and table access
   logic        hi_in, lo_in;
   logic [8:0]  ent_in, ent1_in;
   logic [9:0]  nxt_in;
   logic [15:0] frac_in;

   always_comb begin
      hi_in = s2_clamp_ff && (s2_prod_ff >= $signed({18'd0, s2_dm1_ff, 16'd0}));
      lo_in = s2_clamp_ff && (s2_prod_ff <= 43'sd0);
      if (hi_in) begin
         ent_in = s2_dm1_ff;
      end else if (lo_in) begin
         ent_in = 9'd0;
      end else begin
         ent_in = s2_prod_ff[24:16];
      end
      frac_in = (hi_in || lo_in || snap_ff) ? 16'd0 : s2_prod_ff[15:0];
      nxt_in  = {1'b0, ent_in} + 10'd1;
      ent1_in = (nxt_in >= {1'b0, s2_n_ff}) ? 9'd0 : nxt_in[8:0];
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && !s2_lkp_ff && (32'(s2_addr_ff) < DEPTH)) begin
         mem[AW'(s2_addr_ff)] <= s2_wdat_ff;
      end
      s3_rd0_ff <= mem[AW'(ent_in)];
      s3_rd1_ff <= mem[AW'(ent1_in)];
   end

   // stage 3: blend product
   logic signed [32:0] diff_in;
   logic signed [49:0] mul_in;

   always_comb begin
      diff_in = $signed({s3_rd1_ff[31], s3_rd1_ff}) - $signed({s3_rd0_ff[31], s3_rd0_ff});
      mul_in  = 50'(diff_in * $signed({1'b0, s3_frac_ff}));
   end

   // stage 4: round, select, saturate
   logic signed [49:0] res_in, sat_in;

   always_comb begin
      res_in = 50'(s4_v0_ff) + ((s4_mul_ff + 50'sd32768) >>> 16);
      if (s4_spc_ff) begin
         res_in = 50'(s4_spv_ff);
      end
      if (res_in > SAT_HI) begin
         sat_in = SAT_HI;
      end else if (res_in < SAT_LO) begin
         sat_in = SAT_LO;
      end else begin
         sat_in = res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= start && !busy;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff && s2_lkp_ff;
         s4_vld_ff    <= s3_vld_ff;
         rsp_valid_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_lkp_ff   <= (req_cmd == tlu_pkg::CMD_LOOKUP);
      s1_addr_ff  <= req_entry_address;
      s1_wdat_ff  <= req_entry_value;
      s1_idx_ff   <= req_lookup_index;
      s2_lkp_ff   <= s1_lkp_ff;
      s2_addr_ff  <= s1_addr_ff;
      s2_wdat_ff  <= s1_wdat_ff;
      s2_prod_ff  <= prod_in;
      s2_clamp_ff <= clamp_ff;
      s2_n_ff     <= n_in;
      s2_dm1_ff   <= dm1_in;
      s2_spc_ff   <= spc_in;
      s2_spv_ff   <= spv_in;
      s3_frac_ff  <= frac_in;
      s3_spc_ff   <= s2_spc_ff;
      s3_spv_ff   <= s2_spv_ff;
      s4_mul_ff   <= mul_in;
      s4_v0_ff    <= s3_rd0_ff;
      s4_spc_ff   <= s3_spc_ff;
      s4_spv_ff   <= s3_spv_ff;
      rsp_result_ff <= 32'(sat_in);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lookup_result = rsp_result_ff;

`ifndef SYNTH
   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_cmd == tlu_pkg::CMD_LOOKUP), 5))
      else $error("result without lookup");
   a_lookup_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == tlu_pkg::CMD_LOOKUP)) |-> ##5 rsp_valid)
      else $error("lookup lost");
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == tlu_pkg::CMD_WRITE)) |-> ##5 !rsp_valid)
      else $error("write produced result");
   a_pinned_frac: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && (hi_in || lo_in)) |=> (s3_frac_ff == 16'd0))
      else $error("pinned lookup blends");
`endif
endmodule
